// ----- rtl/dwrm_pkg.sv -----
package dwrm_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int POS_W         = 4;
    localparam int STATUS_W      = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE_MAX = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LIST_BACK  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] item_value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic [POS_W-1:0]         position;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } result_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT_LEFT,
        CELL_ROT_RIGHT,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_COMPACT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

// ----- rtl/dwrm_cell.sv -----
module dwrm_cell
    import dwrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int INDEX = 0,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic [IDX_W-1:0]         sel_index,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     is_sel;
    logic                     at_or_after_sel;

    assign is_sel          = (sel_index == IDX_W'(INDEX));
    assign at_or_after_sel = (sel_index <= IDX_W'(INDEX));

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_HOLD:       data_next = data_reg;
            CELL_ROT_LEFT:   data_next = right_data;
            CELL_ROT_RIGHT:  data_next = left_data;
            CELL_PUSH_FRONT: data_next = (INDEX == 0) ? ctl.value : left_data;
            CELL_PUSH_BACK:  data_next = is_sel ? ctl.value : data_reg;
            // close the gap: entries behind the removed one move toward the front
            CELL_COMPACT:    data_next = at_or_after_sel ? right_data : data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/dwrm_ctrl.sv -----
module dwrm_ctrl
    import dwrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  cmd_t                     cmd,
    input  logic signed [DATA_W-1:0] head_value,
    input  logic signed [DATA_W-1:0] tail_value,
    output logic                     busy,
    output cell_ctl_t                cell_ctl,
    output logic [IDX_W-1:0]         sel_index,
    output result_t                  result,
    output logic                     strobe
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_COMPACT
    } state_t;

    state_t                   state_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic [IDX_W-1:0]         step_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         best_reg;
    logic signed [DATA_W-1:0] max_reg;
    result_t                  result_reg;
    logic                     strobe_reg;

    logic             full;
    logic             empty;
    logic [CNT_W-1:0] step_ext;
    logic             step_end;
    logic             in_live;
    logic [CNT_W-1:0] back_start;
    logic [CNT_W-1:0] back_pos;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign step_ext   = CNT_W'(step_reg);
    assign step_end   = (step_reg == IDX_W'(DEPTH - 1));
    assign in_live    = (step_ext < count_reg);
    assign back_start = CNT_W'(DEPTH) - count_reg;
    assign back_pos   = step_ext - back_start;
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        cell_ctl.op    = CELL_HOLD;
        cell_ctl.value = cmd.item_value;
        sel_index      = best_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && !full)
                begin
                    if (cmd.mode == MODE_PUSH_FRONT)
                    begin
                        cell_ctl.op = CELL_PUSH_FRONT;
                    end
                    else if (cmd.mode == MODE_PUSH_BACK)
                    begin
                        cell_ctl.op = CELL_PUSH_BACK;
                        sel_index   = count_reg[IDX_W-1:0];
                    end
                end
            end
            ST_ROTATE:
            begin
                cell_ctl.op = (mode_reg == MODE_LIST_BACK) ? CELL_ROT_RIGHT : CELL_ROT_LEFT;
            end
            ST_COMPACT:
            begin
                cell_ctl.op = CELL_COMPACT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_PUSH_FRONT;
            step_reg   <= '0;
            count_reg  <= '0;
            best_reg   <= '0;
            max_reg    <= '0;
            result_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        unique case (cmd.mode)
                            MODE_PUSH_FRONT, MODE_PUSH_BACK:
                            begin
                                if (full)
                                begin
                                    result_reg <= '{out_value: '0, position: '0,
                                                    status: STATUS_FULL, last: 1'b1};
                                    strobe_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            MODE_REMOVE_MAX, MODE_LIST_FRONT, MODE_LIST_BACK:
                            begin
                                if (empty)
                                begin
                                    result_reg <= '{out_value: '0, position: '0,
                                                    status: STATUS_EMPTY, last: 1'b1};
                                    strobe_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_ROTATE;
                                    mode_reg  <= cmd.mode;
                                    step_reg  <= '0;
                                end
                            end
                            MODE_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_ROTATE:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_end)
                    begin
                        state_reg <= (mode_reg == MODE_REMOVE_MAX) ? ST_COMPACT : ST_IDLE;
                    end
                    if (mode_reg == MODE_LIST_FRONT)
                    begin
                        if (in_live)
                        begin
                            result_reg <= '{out_value: head_value,
                                            position: POS_W'(step_ext),
                                            status: STATUS_OK,
                                            last: (step_ext == count_reg - 1'b1)};
                            strobe_reg <= 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_LIST_BACK)
                    begin
                        if (step_ext >= back_start)
                        begin
                            result_reg <= '{out_value: tail_value,
                                            position: POS_W'(back_pos),
                                            status: STATUS_OK,
                                            last: step_end};
                            strobe_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        // strict compare keeps the entry nearest the front on ties
                        if (in_live && ((step_reg == '0) || (head_value > max_reg)))
                        begin
                            max_reg  <= head_value;
                            best_reg <= step_reg;
                        end
                    end
                end
                ST_COMPACT:
                begin
                    result_reg <= '{out_value: max_reg, position: POS_W'(best_reg),
                                    status: STATUS_OK, last: 1'b1};
                    strobe_reg <= 1'b1;
                    count_reg  <= count_reg - 1'b1;
                    state_reg  <= ST_IDLE;
                end
            endcase
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (result_reg.status == STATUS_FULL)) |-> full)
        else $error("full status reported while store not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (result_reg.status == STATUS_EMPTY)) |-> empty)
        else $error("empty status reported while store holds entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !empty)
        else $error("ring walk running on an empty store");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPACT) |=> (strobe_reg && result_reg.last
                                       && (state_reg == ST_IDLE)))
        else $error("remove max did not finish with a final result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROTATE && step_end && mode_reg == MODE_LIST_BACK)
        |=> (strobe_reg && result_reg.last))
        else $error("list-back walk ended without a final result");

endmodule

// ----- rtl/deque_with_remove_max_unit.sv -----
// Bounded double-ended queue of signed 32-bit values with remove-max.
//
// Command channel: drive cmd (mode, item_value) and raise start; the item is
// taken at a rising edge where start is high and busy is low.
// Result channel: each result sits on result for one cycle with strobe high.
// The receiver cannot stall; every result must be taken in its cycle.
//
// Entries live in a ring of DEPTH cells, cell 0 holding the front entry.
// Push front, push back, clear and a refused push finish without leaving idle; a
// refused push shows its full-status result the cycle after the item is taken.
// List front / list back walk the whole ring once, emitting one result per
// cycle for each live entry, busy throughout.
// Remove max walks the ring tracking the largest value, then closes the gap and
// reports its result from the compact state. Remove or list on an empty store
// answers with one empty-status result and stays idle. New commands wait while
// a ring walk through the cell chain keeps busy high.
//
// Reset clears the entry count and the controller; cell contents are not
// cleared and only live entries are ever reported.
module deque_with_remove_max_unit
    import dwrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output result_t result,
    output logic    strobe
);

    localparam int IDX_W = $clog2(DEPTH);

    // cell outputs, each read at a fixed place in the ring
    logic signed [DATA_W-1:0] cell_data [DEPTH];
    cell_ctl_t                cell_ctl;
    logic [IDX_W-1:0]         sel_index;

    // the controller watches the front cell and the last cell of the ring
    dwrm_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .head_value (cell_data[0]),
        .tail_value (cell_data[DEPTH-1]),
        .busy       (busy),
        .cell_ctl   (cell_ctl),
        .sel_index  (sel_index),
        .result     (result),
        .strobe     (strobe)
    );

    // close the chain into a ring so a full walk returns every entry home
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dwrm_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .sel_index  (sel_index),
            .left_data  (cell_data[(i + DEPTH - 1) % DEPTH]),
            .right_data (cell_data[(i + 1) % DEPTH]),
            .data       (cell_data[i])
        );
    end

endmodule
